// File: hw/rtl/tdf_pkg.sv
package tdf_pkg;

    localparam int VALUE_BITS = 31;
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS = 2 * DIV_BITS;
    localparam int S_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVEN,
        ST_TRIAL,
        ST_TAIL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic halve;
        logic start_odd;
        logic step;
        logic take_hit;
        logic push_rem;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_even;
        logic n_gt2;
        logic issue_ok;
        logic busy;
        logic hit;
        logic push_ok;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [DIV_BITS-1:0]   rem;
        logic [VALUE_BITS-1:0] q;
        logic [DIV_BITS-1:0]   d;
        logic [SQ_BITS-1:0]    sq;
    } div_stage_t;

endpackage

// File: hw/rtl/tdf_div_pipe.sv
module tdf_div_pipe (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  logic                            flush,
    input  logic                            in_valid,
    input  logic [tdf_pkg::VALUE_BITS-1:0]  in_n,
    input  logic [tdf_pkg::DIV_BITS-1:0]    in_d,
    input  logic [tdf_pkg::SQ_BITS-1:0]     in_sq,
    output logic                            out_valid,
    output logic                            out_rem_zero,
    output logic [tdf_pkg::VALUE_BITS-1:0]  out_q,
    output logic [tdf_pkg::DIV_BITS-1:0]    out_d,
    output logic [tdf_pkg::SQ_BITS-1:0]     out_sq,
    output logic                            busy
);

    localparam int W = tdf_pkg::VALUE_BITS;
    localparam int DW = tdf_pkg::DIV_BITS;

    // One quotient bit per stage of a restoring division.
    function automatic tdf_pkg::div_stage_t div_step(input tdf_pkg::div_stage_t s);
        logic [DW:0]          r_sh;
        tdf_pkg::div_stage_t o;
        o = s;
        r_sh = {s.rem, s.q[W-1]};
        o.q = {s.q[W-2:0], 1'b0};
        if (r_sh >= {1'b0, s.d}) begin
            o.rem = DW'(r_sh - {1'b0, s.d});
            o.q[0] = 1'b1;
        end else begin
            o.rem = r_sh[DW-1:0];
        end
        return o;
    endfunction

    tdf_pkg::div_stage_t stage_reg [W];
    tdf_pkg::div_stage_t stage_next [W];
    tdf_pkg::div_stage_t first_in;
    logic [W-1:0]        valid_reg;
    logic [W-1:0]        valid_next;

    always_comb begin
        first_in.rem = '0;
        first_in.q = in_n;
        first_in.d = in_d;
        first_in.sq = in_sq;
        stage_next[0] = div_step(first_in);
        for (int k = 1; k < W; k++) begin
            stage_next[k] = div_step(stage_reg[k-1]);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (flush) begin
            valid_next = '0;
        end else if (advance) begin
            valid_next = {valid_reg[W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < W; k++) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[W-1];
    assign out_rem_zero = (stage_reg[W-1].rem == '0);
    assign out_q = stage_reg[W-1].q;
    assign out_d = stage_reg[W-1].d;
    assign out_sq = stage_reg[W-1].sq;
    assign busy = |valid_reg;

endmodule

// File: hw/rtl/tdf_datapath.sv
module tdf_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tdf_pkg::cmd_t                      cmd,
    output tdf_pkg::status_t                   status,
    input  logic [tdf_pkg::VALUE_BITS-1:0]     in_value,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tdf_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic [tdf_pkg::M_TUSER_BITS-1:0]   m_tuser,
    output logic                               m_tlast
);

    localparam int W = tdf_pkg::VALUE_BITS;
    localparam int DW = tdf_pkg::DIV_BITS;
    localparam int SQW = tdf_pkg::SQ_BITS;

    logic [W-1:0]   n_reg, n_next;
    logic [DW-1:0]  d_reg, d_next;
    logic [SQW-1:0] sq_reg, sq_next;
    logic           zero_reg, zero_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [W-1:0]   pend_factor_reg, pend_factor_next;
    logic           m_valid_reg, m_valid_next;
    logic [W-1:0]   m_factor_reg, m_factor_next;
    logic           m_has_reg, m_has_next;
    logic           m_zero_reg, m_zero_next;
    logic           m_last_reg, m_last_next;

    logic           issue_ok;
    logic           issue;
    logic           push_en;
    logic [W-1:0]   push_val;
    logic           out_free;
    logic           hit;
    logic           div_valid;
    logic           div_rem_zero;
    logic [W-1:0]   div_q;
    logic [DW-1:0]  div_d;
    logic [SQW-1:0] div_sq;
    logic           div_busy;

    assign issue_ok = (sq_reg <= SQW'(n_reg));
    assign issue = cmd.step && issue_ok;
    assign out_free = !m_valid_reg || m_tready;
    assign hit = div_valid && div_rem_zero;
    assign push_en = cmd.halve || cmd.take_hit || cmd.push_rem;

    tdf_div_pipe u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (cmd.step),
        .flush        (cmd.take_hit || cmd.start_odd),
        .in_valid     (issue),
        .in_n         (n_reg),
        .in_d         (d_reg),
        .in_sq        (sq_reg),
        .out_valid    (div_valid),
        .out_rem_zero (div_rem_zero),
        .out_q        (div_q),
        .out_d        (div_d),
        .out_sq       (div_sq),
        .busy         (div_busy)
    );

    always_comb begin
        if (cmd.halve) begin
            push_val = W'(2);
        end else if (cmd.take_hit) begin
            push_val = W'(div_d);
        end else begin
            push_val = n_reg;
        end
    end

    always_comb begin
        n_next = n_reg;
        d_next = d_reg;
        sq_next = sq_reg;
        zero_next = zero_reg;
        if (cmd.load) begin
            n_next = in_value;
            zero_next = (in_value == '0);
        end else if (cmd.halve) begin
            n_next = {1'b0, n_reg[W-1:1]};
        end else if (cmd.take_hit) begin
            n_next = div_q;
        end
        if (cmd.start_odd) begin
            d_next = DW'(3);
            sq_next = SQW'(9);
        end else if (cmd.take_hit) begin
            d_next = div_d;
            sq_next = div_sq;
        end else if (issue) begin
            d_next = d_reg + DW'(2);
            sq_next = sq_reg + SQW'({d_reg, 2'b00}) + SQW'(4);
        end
    end

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_factor_next = pend_factor_reg;
        m_valid_next = m_valid_reg;
        m_factor_next = m_factor_reg;
        m_has_next = m_has_reg;
        m_zero_next = m_zero_reg;
        m_last_next = m_last_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load || cmd.finish) begin
            pend_valid_next = 1'b0;
        end else if (push_en) begin
            pend_valid_next = 1'b1;
            pend_factor_next = push_val;
        end
        if (push_en && pend_valid_reg) begin
            m_valid_next = 1'b1;
            m_factor_next = pend_factor_reg;
            m_has_next = 1'b1;
            m_zero_next = 1'b0;
            m_last_next = 1'b0;
        end else if (cmd.finish) begin
            m_valid_next = 1'b1;
            m_last_next = 1'b1;
            if (pend_valid_reg) begin
                m_factor_next = pend_factor_reg;
                m_has_next = 1'b1;
                m_zero_next = 1'b0;
            end else begin
                m_factor_next = '0;
                m_has_next = 1'b0;
                m_zero_next = zero_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;
        d_reg <= d_next;
        sq_reg <= sq_next;
        zero_reg <= zero_next;
        pend_factor_reg <= pend_factor_next;
        m_factor_reg <= m_factor_next;
        m_has_reg <= m_has_next;
        m_zero_reg <= m_zero_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        status.n_zero = (n_reg == '0);
        status.n_even = !n_reg[0];
        status.n_gt2 = (n_reg > W'(2));
        status.issue_ok = issue_ok;
        status.busy = div_busy;
        status.hit = hit;
        status.push_ok = !pend_valid_reg || out_free;
        status.out_free = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = tdf_pkg::M_TDATA_BITS'(m_factor_reg);
    assign m_tuser = {m_zero_reg, m_has_reg};
    assign m_tlast = m_last_reg;

endmodule

// File: hw/rtl/tdf_ctrl.sv
module tdf_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  tdf_pkg::status_t status,
    output tdf_pkg::cmd_t    cmd
);

    tdf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            tdf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    state_next = tdf_pkg::ST_EVEN;
                end
            end
            tdf_pkg::ST_EVEN: begin
                if (status.n_zero) begin
                    state_next = tdf_pkg::ST_FINISH;
                end else if (status.n_even) begin
                    cmd.halve = status.push_ok;
                end else begin
                    cmd.start_odd = 1'b1;
                    state_next = tdf_pkg::ST_TRIAL;
                end
            end
            tdf_pkg::ST_TRIAL: begin
                if (status.hit) begin
                    cmd.take_hit = status.push_ok;
                end else if (!status.issue_ok && !status.busy) begin
                    state_next = tdf_pkg::ST_TAIL;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            tdf_pkg::ST_TAIL: begin
                if (!status.n_gt2) begin
                    state_next = tdf_pkg::ST_FINISH;
                end else if (status.push_ok) begin
                    cmd.push_rem = 1'b1;
                    state_next = tdf_pkg::ST_FINISH;
                end
            end
            tdf_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = tdf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/trial_division_factorizer.sv
// Prime factorizer by trial division. The slave channel takes one non-negative
// integer per transaction, and the master channel returns its prime factors in
// ascending order, with repeats, one factor per transaction; m_tlast marks the
// final one. An input of zero or one returns a single transaction with no
// factor, and zero also sets the zero-input flag.
// One input is worked on at a time; s_tready is high only while the block is
// idle. Factors of two are removed first by halving. Odd divisors from 3 up
// are fed into a pipelined restoring divider at one per cycle, unless a found
// factor waits on the output, while the divisor squared is at most the
// remaining value. Each odd factor found flushes the divider and restarts the
// search at that divisor; the search ends once the divider has drained.
// The last factor is held back one step so that it can carry m_tlast, and the
// output register lets the next input be taken while the final transaction
// still waits. When the receiver stalls, the divider pipeline freezes as soon
// as a new factor has nowhere to go, and resumes without loss.
// Reset (aresetn low, synchronous) returns the block to idle and drops any
// result that was not yet delivered.
module trial_division_factorizer (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tdf_pkg::S_TDATA_BITS-1:0]   s_tdata,  // value, then zero padding
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tdf_pkg::M_TDATA_BITS-1:0]   m_tdata,  // factor, then zero padding
    output logic [tdf_pkg::M_TUSER_BITS-1:0]   m_tuser,  // bit 1 zero_input, bit 0 has_factor
    output logic                               m_tlast
);

    tdf_pkg::cmd_t    cmd;
    tdf_pkg::status_t status;

    tdf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tdf_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_value (s_tdata[tdf_pkg::VALUE_BITS-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
